/* rtl/crgt_pkg.sv */
package crgt_pkg;

	localparam int MAX_REGIONS = 8;
	localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [2:0] {
		OP_ARM     = 3'd0,
		OP_ISSUED  = 3'd1,
		OP_RELEASE = 3'd2,
		OP_BLOCKED = 3'd3,
		OP_PHASE   = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_ZERO_LAYER   = 4'd1,
		ST_ZERO_CMD_ID  = 4'd2,
		ST_ORDER        = 4'd3,
		ST_DUPLICATE    = 4'd4,
		ST_FULL         = 4'd5,
		ST_UNARMED      = 4'd6,
		ST_RELEASED     = 4'd7,
		ST_NOT_REACHED  = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_ARMED    = 2'd1,
		PH_REACHED  = 2'd2,
		PH_RELEASED = 2'd3
	} phase_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_SCAN
	} fsm_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] layer;
		logic [31:0] insert_after_id;
		logic [31:0] resume_before_id;
		logic [31:0] resume_idx;
		logic [31:0] cmd_id;
		logic [31:0] cmd_index;
	} item_t;

	// token walking down the cell chain, gathering table facts
	typedef struct packed {
		logic       valid;
		logic       found;
		idx_t       found_idx;
		phase_t     found_phase;
		logic       free_ok;
		idx_t       free_idx;
		logic       blocked;
		logic       any_valid;
		logic [1:0] nonrel;
	} tok_t;

	typedef struct packed {
		logic        arm_we;
		logic        rel_we;
		idx_t        idx;
		logic [31:0] layer;
		logic [31:0] insert_id;
		logic [31:0] resume_idx;
	} commit_t;

	typedef struct packed {
		status_t status;
		logic    blocked;
		phase_t  region_phase;
		logic    all_released;
	} result_t;

endpackage

/* rtl/crgt_cell.sv */
module crgt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  crgt_pkg::idx_t    idx,
	input  crgt_pkg::item_t   item,
	input  crgt_pkg::commit_t cm,
	input  crgt_pkg::tok_t    tok_i,
	output crgt_pkg::tok_t    tok_o
);

	logic             valid_q;
	crgt_pkg::phase_t phase_q;
	logic [31:0]      layer_q;
	logic [31:0]      insert_q;
	logic [31:0]      resume_q;
	crgt_pkg::tok_t   tok_q;
	crgt_pkg::tok_t   tok_d;
	logic             hit;
	logic             issue_hit;
	logic             my_commit;

	assign hit = valid_q && (layer_q == item.layer);
	assign issue_hit = tok_i.valid && (item.op == crgt_pkg::OP_ISSUED) && valid_q
		&& (phase_q == crgt_pkg::PH_ARMED) && (insert_q == item.cmd_id);
	assign my_commit = (cm.idx == idx);

	always_comb begin
		tok_d = tok_i;
		if (hit && !tok_i.found) begin
			tok_d.found       = 1'b1;
			tok_d.found_idx   = idx;
			tok_d.found_phase = phase_q;
		end
		if (!valid_q && !tok_i.free_ok) begin
			tok_d.free_ok  = 1'b1;
			tok_d.free_idx = idx;
		end
		if (valid_q && (phase_q == crgt_pkg::PH_REACHED)
				&& (item.cmd_index >= resume_q)) begin
			tok_d.blocked = 1'b1;
		end
		if (valid_q) begin
			tok_d.any_valid = 1'b1;
		end
		if (valid_q && (phase_q != crgt_pkg::PH_RELEASED) && (tok_i.nonrel != 2'd2)) begin
			tok_d.nonrel = tok_i.nonrel + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			valid_q <= 1'b0;
			phase_q <= crgt_pkg::PH_IDLE;
		end else begin
			tok_q <= tok_d;
			if (cm.arm_we && my_commit) begin
				valid_q <= 1'b1;
				phase_q <= crgt_pkg::PH_ARMED;
			end else if (cm.rel_we && my_commit) begin
				phase_q <= crgt_pkg::PH_RELEASED;
			end else if (issue_hit) begin
				phase_q <= crgt_pkg::PH_REACHED;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cm.arm_we && my_commit) begin
			layer_q  <= cm.layer;
			insert_q <= cm.insert_id;
			resume_q <= cm.resume_idx;
		end
	end

	assign tok_o = tok_q;

endmodule

/* rtl/command_region_gate_table_top.sv */
// a request is registered on accept, then its token walks the registered cell chain
// and the result is decided as the token leaves the chain; a new request is accepted
// only after the token has left the chain and the control has returned to idle
// a result waiting at the output does not stop the next request; a skid register holds one more
// reset: arst_n clears the whole table to idle and empties the output side
module command_region_gate_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  op,
	input  logic [31:0] layer,
	input  logic [31:0] insert_after_id,
	input  logic [31:0] resume_before_id,
	input  logic [31:0] resume_idx,
	input  logic [31:0] cmd_id,
	input  logic [31:0] cmd_index,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [3:0]  status,
	output logic        blocked,
	output logic [1:0]  region_phase,
	output logic        all_released
);

	crgt_pkg::fsm_t    state_q;
	crgt_pkg::fsm_t    state_d;
	crgt_pkg::item_t   item_q;
	logic              launch_q;
	crgt_pkg::tok_t    chain [crgt_pkg::MAX_REGIONS+1];
	crgt_pkg::tok_t    tok_end;
	crgt_pkg::commit_t cm;
	crgt_pkg::result_t res_new;
	crgt_pkg::result_t out_q;
	crgt_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              accept;
	logic              take;
	logic              done;

	// state machine
	always_comb begin
		state_d = state_q;
		case (state_q)
			crgt_pkg::FSM_IDLE: begin
				if (accept) begin
					state_d = crgt_pkg::FSM_SCAN;
				end
			end
			crgt_pkg::FSM_SCAN: begin
				if (done) begin
					state_d = crgt_pkg::FSM_IDLE;
				end
			end
			default: state_d = crgt_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != crgt_pkg::FSM_IDLE) || skid_valid_q;
	end

	assign accept = req_valid && !req_stall;
	assign take   = out_valid_q && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= crgt_pkg::FSM_IDLE;
			launch_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.op               <= crgt_pkg::op_t'(op);
			item_q.layer            <= layer;
			item_q.insert_after_id  <= insert_after_id;
			item_q.resume_before_id <= resume_before_id;
			item_q.resume_idx       <= resume_idx;
			item_q.cmd_id           <= cmd_id;
			item_q.cmd_index        <= cmd_index;
		end
	end

	// cell chain
	always_comb begin
		chain[0]       = '0;
		chain[0].valid = launch_q;
	end

	for (genvar g = 0; g < crgt_pkg::MAX_REGIONS; g++) begin : g_cell
		crgt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (crgt_pkg::idx_t'(g)),
			.item   (item_q),
			.cm     (cm),
			.tok_i  (chain[g]),
			.tok_o  (chain[g+1])
		);
	end

	assign tok_end = chain[crgt_pkg::MAX_REGIONS];
	assign done    = tok_end.valid;

	// decide the request once the token leaves the chain
	always_comb begin
		res_new              = '0;
		res_new.status       = crgt_pkg::ST_OK;
		res_new.region_phase = crgt_pkg::PH_IDLE;
		cm                   = '0;
		cm.layer             = item_q.layer;
		cm.insert_id         = item_q.insert_after_id;
		cm.resume_idx        = item_q.resume_idx;
		case (item_q.op)
			crgt_pkg::OP_ARM: begin
				cm.idx = tok_end.free_idx;
				if (item_q.layer == 32'd0) begin
					res_new.status = crgt_pkg::ST_ZERO_LAYER;
				end else if ((item_q.insert_after_id == 32'd0)
						|| (item_q.resume_before_id == 32'd0)) begin
					res_new.status = crgt_pkg::ST_ZERO_CMD_ID;
				end else if (item_q.insert_after_id >= item_q.resume_before_id) begin
					res_new.status = crgt_pkg::ST_ORDER;
				end else if (tok_end.found) begin
					res_new.status = crgt_pkg::ST_DUPLICATE;
				end else if (!tok_end.free_ok) begin
					res_new.status = crgt_pkg::ST_FULL;
				end else begin
					cm.arm_we = done;
				end
			end
			crgt_pkg::OP_RELEASE: begin
				cm.idx = tok_end.found_idx;
				if (!tok_end.found) begin
					res_new.status = crgt_pkg::ST_UNARMED;
				end else if (tok_end.found_phase == crgt_pkg::PH_RELEASED) begin
					res_new.status = crgt_pkg::ST_RELEASED;
				end else if (tok_end.found_phase != crgt_pkg::PH_REACHED) begin
					res_new.status = crgt_pkg::ST_NOT_REACHED;
				end else begin
					cm.rel_we = done;
				end
			end
			crgt_pkg::OP_BLOCKED: begin
				res_new.blocked = tok_end.blocked;
			end
			crgt_pkg::OP_PHASE: begin
				if (tok_end.found) begin
					res_new.region_phase = tok_end.found_phase;
				end
			end
			default: begin
			end
		endcase
		if (cm.arm_we) begin
			res_new.all_released = 1'b0;
		end else if (cm.rel_we) begin
			res_new.all_released = tok_end.any_valid && (tok_end.nonrel == 2'd1);
		end else begin
			res_new.all_released = tok_end.any_valid && (tok_end.nonrel == 2'd0);
		end
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (done) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (!out_valid_q || take) begin
				out_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign res_valid    = out_valid_q;
	assign status       = out_q.status;
	assign blocked      = out_q.blocked;
	assign region_phase = out_q.region_phase;
	assign all_released = out_q.all_released;

endmodule
